// ----- hdl/rbmga_pkg.sv -----
// Shared types, sizes and codes of the gradient accumulator.
package rbmga_pkg;

    // Sizes of the network.
    localparam int VISIBLE_COUNT = 256;
    localparam int HIDDEN_COUNT  = 64;

    // Field widths of the input and result transactions.
    localparam int MODE_W = 3;
    localparam int HID_W  = 6;
    localparam int VIS_W  = 8;
    localparam int VAL_W  = 16;
    localparam int FAC_W  = 16;
    localparam int ACC_W  = 32;

    // Layout of the accumulator memory: weights row by row, then the hidden
    // biases, then the visible biases.
    localparam int WEIGHT_COUNT = HIDDEN_COUNT * VISIBLE_COUNT;
    localparam int HB_BASE      = WEIGHT_COUNT;
    localparam int VB_BASE      = WEIGHT_COUNT + HIDDEN_COUNT;
    localparam int ACC_DEPTH    = VB_BASE + VISIBLE_COUNT;
    localparam int ACC_AW       = $clog2(ACC_DEPTH);
    localparam int VIS_AW       = (VISIBLE_COUNT > 1) ? $clog2(VISIBLE_COUNT) : 1;

    // A hidden state of one in Q1.15.
    localparam logic [VAL_W-1:0] ONE_Q15 = 16'h8000;

    // Transaction modes.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROW     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCALE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_WGT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RD_HB   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RD_VB   = 3'd5;

    // Operation that a sweep over the accumulator memory performs.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_ROW,
        OP_SCALE,
        OP_READ
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_RESULT
    } t_state;

    // Control of the update unit for one accumulator entry.
    typedef struct packed {
        t_op  op;
        logic neg;
        logic bias;
    } t_alu_ctl;

endpackage

// ----- hdl/rbmga_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module rbmga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/rbmga_alu.sv -----
// Update unit: saturating add or subtract, floor scaling, and clearing.
module rbmga_alu (
    input  rbmga_pkg::t_alu_ctl                   i_ctl,
    input  logic signed [rbmga_pkg::ACC_W-1:0]    i_acc,
    input  logic [rbmga_pkg::VAL_W-1:0]           i_store,
    input  logic [rbmga_pkg::VAL_W-1:0]           i_load_val,
    input  logic [rbmga_pkg::FAC_W-1:0]           i_factor,
    output logic signed [rbmga_pkg::ACC_W-1:0]    o_result
);

    logic signed [rbmga_pkg::ACC_W+rbmga_pkg::FAC_W:0] w_prod;
    logic [rbmga_pkg::ACC_W-1:0]                       w_scaled;
    logic [rbmga_pkg::VAL_W-1:0]                       w_delta;
    logic signed [rbmga_pkg::ACC_W:0]                  w_sum;
    logic [rbmga_pkg::ACC_W-1:0]                       w_sat;

    // Scaling: exact product with the Q0.16 factor, then an arithmetic shift,
    // which rounds toward minus infinity.
    assign w_prod   = i_acc * $signed({1'b0, i_factor});
    assign w_scaled = w_prod[rbmga_pkg::ACC_W+rbmga_pkg::FAC_W-1:rbmga_pkg::FAC_W];

    // The contribution is the loaded value, one for a hidden bias, or the
    // stored visible value.
    always_comb begin
        if (i_ctl.op == rbmga_pkg::OP_LOAD) begin
            w_delta = i_load_val;
        end else if (i_ctl.bias) begin
            w_delta = rbmga_pkg::ONE_Q15;
        end else begin
            w_delta = i_store;
        end
    end

    // Add or subtract with one guard bit, then clamp on overflow.
    always_comb begin
        if (i_ctl.neg) begin
            w_sum = {i_acc[rbmga_pkg::ACC_W-1], i_acc}
                    - $signed({{(rbmga_pkg::ACC_W+1-rbmga_pkg::VAL_W){1'b0}}, w_delta});
        end else begin
            w_sum = {i_acc[rbmga_pkg::ACC_W-1], i_acc}
                    + $signed({{(rbmga_pkg::ACC_W+1-rbmga_pkg::VAL_W){1'b0}}, w_delta});
        end
        if (w_sum[rbmga_pkg::ACC_W] != w_sum[rbmga_pkg::ACC_W-1]) begin
            w_sat = w_sum[rbmga_pkg::ACC_W] ? {1'b1, {(rbmga_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(rbmga_pkg::ACC_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[rbmga_pkg::ACC_W-1:0];
        end
    end

    // Select the new entry value.
    always_comb begin
        case (i_ctl.op) inside
            rbmga_pkg::OP_CLEAR: o_result = '0;
            rbmga_pkg::OP_SCALE: o_result = w_scaled;
            rbmga_pkg::OP_LOAD,
            rbmga_pkg::OP_ROW:   o_result = w_sat;
            default:             o_result = i_acc;
        endcase
    end

endmodule

// ----- hdl/rbm_gradient_accumulator.sv -----
// Top level of the RBM gradient accumulator: sequencer over the accumulator memory.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_mode, i_negative_phase, indexes,
//          |           |                            | i_visible_value, i_hidden_value,
//          |           |                            | i_scale_factor
//  out     | output    | o_out_valid / i_out_ready  | o_read_value
//
// All accumulators share one memory with one read and one write port; the
// sequencer reads one entry a cycle and writes it back in the next cycle.
// After reset a clearing pass writes zero to all ACC_DEPTH (16704) entries, with o_in_ready low.
// A waiting result does not stop new transactions; only a second read waits for
// the output register to empty.
module rbm_gradient_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rbmga_pkg::MODE_W-1:0]          i_mode,
    input  logic                                  i_negative_phase,
    input  logic [rbmga_pkg::HID_W-1:0]           i_hidden_index,
    input  logic [rbmga_pkg::VIS_W-1:0]           i_visible_index,
    input  logic [rbmga_pkg::VAL_W-1:0]           i_visible_value,
    input  logic                                  i_hidden_value,
    input  logic [rbmga_pkg::FAC_W-1:0]           i_scale_factor,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rbmga_pkg::ACC_W-1:0]    o_read_value
);

    // Control registers.
    rbmga_pkg::t_state                r_state, n_state;
    rbmga_pkg::t_op                   r_op, n_op;
    logic [rbmga_pkg::ACC_AW-1:0]     r_cnt, n_cnt;
    logic [rbmga_pkg::ACC_AW-1:0]     r_last, n_last;
    logic [rbmga_pkg::ACC_AW-1:0]     r_base, n_base;
    logic                             r_p_valid, n_p_valid;
    logic                             r_out_valid, n_out_valid;

    // Payload registers.
    logic [rbmga_pkg::ACC_AW-1:0]     r_hb_addr, n_hb_addr;
    logic                             r_neg, n_neg;
    logic [rbmga_pkg::VAL_W-1:0]      r_vval, n_vval;
    logic [rbmga_pkg::FAC_W-1:0]      r_factor, n_factor;
    logic                             r_zero, n_zero;
    logic [rbmga_pkg::ACC_AW-1:0]     r_p_addr;
    logic                             r_p_bias;
    logic [rbmga_pkg::ACC_W-1:0]      r_res, n_res;
    logic [rbmga_pkg::ACC_W-1:0]      r_out_data, n_out_data;

    // Datapath wires.
    logic                             w_accept;
    logic                             w_h_ok;
    logic                             w_v_ok;
    logic [rbmga_pkg::ACC_AW-1:0]     w_row_base;
    logic                             w_bias_elem;
    logic [rbmga_pkg::ACC_AW-1:0]     w_elem_addr;
    logic [rbmga_pkg::ACC_W-1:0]      w_acc_rdata;
    logic [rbmga_pkg::ACC_W-1:0]      w_acc_wdata;
    logic                             w_acc_we;
    logic [rbmga_pkg::VAL_W-1:0]      w_store_rdata;
    logic                             w_store_we;
    rbmga_pkg::t_alu_ctl              w_alu_ctl;

    assign o_in_ready  = (r_state == rbmga_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_h_ok      = 32'(i_hidden_index) < rbmga_pkg::HIDDEN_COUNT;
    assign w_v_ok      = 32'(i_visible_index) < rbmga_pkg::VISIBLE_COUNT;
    assign w_row_base  = rbmga_pkg::ACC_AW'(i_hidden_index)
                         * rbmga_pkg::ACC_AW'(rbmga_pkg::VISIBLE_COUNT);

    // The element after the last visible unit of a row is its hidden bias.
    assign w_bias_elem = (r_op == rbmga_pkg::OP_ROW) && (r_cnt == r_last);
    assign w_elem_addr = w_bias_elem ? r_hb_addr : r_base + r_cnt;

    // Visible values are written on acceptance of a load transaction.
    assign w_store_we  = w_accept && (i_mode == rbmga_pkg::MODE_LOAD) && w_v_ok;

    rbmga_ram #(
        .WIDTH (rbmga_pkg::VAL_W),
        .DEPTH (rbmga_pkg::VISIBLE_COUNT)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (rbmga_pkg::VIS_AW'(i_visible_index)),
        .i_wdata (i_visible_value),
        .i_raddr (rbmga_pkg::VIS_AW'(r_cnt)),
        .o_rdata (w_store_rdata)
    );

    // Write back the entry read in the previous cycle; reads leave memory unchanged.
    assign w_acc_we  = r_p_valid && (r_op != rbmga_pkg::OP_READ);
    assign w_alu_ctl = '{op: r_op, neg: r_neg, bias: r_p_bias};

    rbmga_ram #(
        .WIDTH (rbmga_pkg::ACC_W),
        .DEPTH (rbmga_pkg::ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (r_p_addr),
        .i_wdata (w_acc_wdata),
        .i_raddr (w_elem_addr),
        .o_rdata (w_acc_rdata)
    );

    rbmga_alu u_alu (
        .i_ctl      (w_alu_ctl),
        .i_acc      (w_acc_rdata),
        .i_store    (w_store_rdata),
        .i_load_val (r_vval),
        .i_factor   (r_factor),
        .o_result   (w_acc_wdata)
    );

    // Sequencer: decode, sweep, flush and result hand-off.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_base      = r_base;
        n_hb_addr   = r_hb_addr;
        n_neg       = r_neg;
        n_vval      = r_vval;
        n_factor    = r_factor;
        n_zero      = r_zero;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_p_valid   = (r_state == rbmga_pkg::ST_RUN);
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            rbmga_pkg::ST_IDLE: begin
                n_cnt    = '0;
                n_last   = '0;
                n_neg    = i_negative_phase;
                n_vval   = i_visible_value;
                n_factor = i_scale_factor;
                n_zero   = 1'b0;
                if (w_accept) begin
                    unique case (i_mode)
                        rbmga_pkg::MODE_LOAD: begin
                            if (w_v_ok) begin
                                n_state = rbmga_pkg::ST_RUN;
                                n_op    = rbmga_pkg::OP_LOAD;
                                n_base  = rbmga_pkg::ACC_AW'(rbmga_pkg::VB_BASE)
                                          + rbmga_pkg::ACC_AW'(i_visible_index);
                            end
                        end
                        rbmga_pkg::MODE_ROW: begin
                            if (w_h_ok && i_hidden_value) begin
                                n_state   = rbmga_pkg::ST_RUN;
                                n_op      = rbmga_pkg::OP_ROW;
                                n_base    = w_row_base;
                                n_last    = rbmga_pkg::ACC_AW'(rbmga_pkg::VISIBLE_COUNT);
                                n_hb_addr = rbmga_pkg::ACC_AW'(rbmga_pkg::HB_BASE)
                                            + rbmga_pkg::ACC_AW'(i_hidden_index);
                            end
                        end
                        rbmga_pkg::MODE_SCALE: begin
                            n_state = rbmga_pkg::ST_RUN;
                            n_op    = rbmga_pkg::OP_SCALE;
                            n_base  = '0;
                            n_last  = rbmga_pkg::ACC_AW'(rbmga_pkg::ACC_DEPTH - 1);
                        end
                        rbmga_pkg::MODE_RD_WGT: begin
                            n_state = rbmga_pkg::ST_RUN;
                            n_op    = rbmga_pkg::OP_READ;
                            n_zero  = !(w_h_ok && w_v_ok);
                            n_base  = w_row_base + rbmga_pkg::ACC_AW'(i_visible_index);
                        end
                        rbmga_pkg::MODE_RD_HB: begin
                            n_state = rbmga_pkg::ST_RUN;
                            n_op    = rbmga_pkg::OP_READ;
                            n_zero  = !w_h_ok;
                            n_base  = rbmga_pkg::ACC_AW'(rbmga_pkg::HB_BASE)
                                      + rbmga_pkg::ACC_AW'(i_hidden_index);
                        end
                        rbmga_pkg::MODE_RD_VB: begin
                            n_state = rbmga_pkg::ST_RUN;
                            n_op    = rbmga_pkg::OP_READ;
                            n_zero  = !w_v_ok;
                            n_base  = rbmga_pkg::ACC_AW'(rbmga_pkg::VB_BASE)
                                      + rbmga_pkg::ACC_AW'(i_visible_index);
                        end
                        default: begin
                            n_state = rbmga_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rbmga_pkg::ST_RUN: begin
                // Issue one read a cycle; the last one moves on to the flush.
                if (r_cnt == r_last) begin
                    n_state = rbmga_pkg::ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rbmga_pkg::ST_FLUSH: begin
                // The last entry is written back here, or a read is captured.
                if (r_op == rbmga_pkg::OP_READ) begin
                    n_res   = r_zero ? '0 : w_acc_rdata;
                    n_state = rbmga_pkg::ST_RESULT;
                end else begin
                    n_state = rbmga_pkg::ST_IDLE;
                end
            end
            rbmga_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = rbmga_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbmga_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbmga_pkg::ST_RUN;
            r_op        <= rbmga_pkg::OP_CLEAR;
            r_cnt       <= '0;
            r_last      <= rbmga_pkg::ACC_AW'(rbmga_pkg::ACC_DEPTH - 1);
            r_base      <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_base      <= n_base;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers and the write-back stage.
    always_ff @(posedge i_clk) begin
        r_hb_addr  <= n_hb_addr;
        r_neg      <= n_neg;
        r_vval     <= n_vval;
        r_factor   <= n_factor;
        r_zero     <= n_zero;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_p_addr   <= w_elem_addr;
        r_p_bias   <= w_bias_elem;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_data;

endmodule

// ----- tb/tb_rbm_gradient_accumulator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RBM gradient accumulator with randomized traffic and stalls.
module tb_rbm_gradient_accumulator;
    import rbmga_pkg::*;

    // Run shape and limits.
    localparam int RANDOM_CMDS = 680;
    localparam int MAX_GAP     = 14;
    localparam int TAIL_CYCLES = ACC_DEPTH + 64;
    localparam int STALL_LIMIT = 4 * ACC_DEPTH;
    localparam int MAX_REPORTS = 10;

    // Mode codes that the block ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    // Saturation bounds of an accumulator.
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    // One input transaction.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic              neg;
        logic [HID_W-1:0]  hid;
        logic [VIS_W-1:0]  vis;
        logic [VAL_W-1:0]  vval;
        logic              hval;
        logic [FAC_W-1:0]  fac;
    } t_grad_cmd;

    // Block ports.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [MODE_W-1:0]       i_mode = '0;
    logic                    i_negative_phase = 1'b0;
    logic [HID_W-1:0]        i_hidden_index = '0;
    logic [VIS_W-1:0]        i_visible_index = '0;
    logic [VAL_W-1:0]        i_visible_value = '0;
    logic                    i_hidden_value = 1'b0;
    logic [FAC_W-1:0]        i_scale_factor = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b1;
    logic signed [ACC_W-1:0] o_read_value;

    // Mirror of the accumulator state, updated as transactions are accepted.
    int              wgt_acc [0:WEIGHT_COUNT-1];
    int              hb_acc  [0:HIDDEN_COUNT-1];
    int              vb_acc  [0:VISIBLE_COUNT-1];
    logic [VAL_W-1:0] vis_mem [0:VISIBLE_COUNT-1];

    // Stimulus and expected read values.
    t_grad_cmd pending_cmds[$];
    int        expected_reads[$];

    t_grad_cmd cur_cmd;
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_results = 0;
    int        n_errors = 0;
    int        in_gap = 0;
    int        out_gap = 0;
    int        idle_cycles = 0;
    int        mode_count [0:7];

    rbm_gradient_accumulator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_negative_phase (i_negative_phase),
        .i_hidden_index   (i_hidden_index),
        .i_visible_index  (i_visible_index),
        .i_visible_value  (i_visible_value),
        .i_hidden_value   (i_hidden_value),
        .i_scale_factor   (i_scale_factor),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_value     (o_read_value)
    );

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Saturating add of a signed step to an accumulator.
    function automatic int sat_sum(int acc, longint delta);
        longint s;
        s = longint'(acc) + delta;
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        return int'(s);
    endfunction

    // A Q1.15 value as a step, negated in the negative phase.
    function automatic longint phase_step(logic [VAL_W-1:0] val, logic neg);
        return neg ? -longint'(val) : longint'(val);
    endfunction

    // Product with a Q0.16 factor; the arithmetic shift rounds toward minus infinity.
    function automatic int scaled(int acc, logic [FAC_W-1:0] fac);
        longint p;
        p = longint'(acc) * longint'({48'd0, fac});
        return int'(p >>> 16);
    endfunction

    // Apply one accepted transaction to the mirror and queue any read value it returns.
    function automatic void accumulate_cmd(t_grad_cmd c);
        int base;
        int i;
        int hid;
        int vis;
        hid = int'(c.hid);
        vis = int'(c.vis);
        case (c.mode)
            MODE_LOAD: begin
                if (vis < VISIBLE_COUNT) begin
                    vis_mem[vis] = c.vval;
                    vb_acc[vis] = sat_sum(vb_acc[vis], phase_step(c.vval, c.neg));
                end
            end
            MODE_ROW: begin
                if (hid < HIDDEN_COUNT && c.hval) begin
                    base = hid * VISIBLE_COUNT;
                    for (i = 0; i < VISIBLE_COUNT; i++) begin
                        wgt_acc[base + i] = sat_sum(wgt_acc[base + i],
                                                    phase_step(vis_mem[i], c.neg));
                    end
                    hb_acc[hid] = sat_sum(hb_acc[hid], phase_step(ONE_Q15, c.neg));
                end
            end
            MODE_SCALE: begin
                for (i = 0; i < WEIGHT_COUNT; i++) wgt_acc[i] = scaled(wgt_acc[i], c.fac);
                for (i = 0; i < HIDDEN_COUNT; i++) hb_acc[i] = scaled(hb_acc[i], c.fac);
                for (i = 0; i < VISIBLE_COUNT; i++) vb_acc[i] = scaled(vb_acc[i], c.fac);
            end
            MODE_RD_WGT: begin
                expected_reads.push_back((hid < HIDDEN_COUNT && vis < VISIBLE_COUNT) ?
                                         wgt_acc[hid * VISIBLE_COUNT + vis] : 0);
            end
            MODE_RD_HB: begin
                expected_reads.push_back((hid < HIDDEN_COUNT) ? hb_acc[hid] : 0);
            end
            MODE_RD_VB: begin
                expected_reads.push_back((vis < VISIBLE_COUNT) ? vb_acc[vis] : 0);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_grad_cmd make_cmd(logic [MODE_W-1:0] mode, logic neg,
                                           logic [HID_W-1:0] hid, logic [VIS_W-1:0] vis,
                                           logic [VAL_W-1:0] vval, logic hval,
                                           logic [FAC_W-1:0] fac);
        t_grad_cmd c;
        c.mode = mode;
        c.neg  = neg;
        c.hid  = hid;
        c.vis  = vis;
        c.vval = vval;
        c.hval = hval;
        c.fac  = fac;
        return c;
    endfunction

    // Every field random; the mode decides which ones matter.
    function automatic t_grad_cmd random_cmd(logic [MODE_W-1:0] mode);
        return make_cmd(mode, 1'($urandom), HID_W'($urandom), VIS_W'($urandom),
                        VAL_W'($urandom), 1'($urandom), FAC_W'($urandom));
    endfunction

    // Wait before the next transaction, none during quiet stretches.
    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic drive_cmd(t_grad_cmd c);
        i_mode           <= c.mode;
        i_negative_phase <= c.neg;
        i_hidden_index   <= c.hid;
        i_visible_index  <= c.vis;
        i_visible_value  <= c.vval;
        i_hidden_value   <= c.hval;
        i_scale_factor   <= c.fac;
    endtask

    // Input driver: presents pending transactions with random gaps in between.
    always @(posedge i_clk) begin : driver_p
        int g;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (i_in_valid && o_in_ready) begin
            accumulate_cmd(cur_cmd);
            mode_count[cur_cmd.mode]++;
            n_accepted++;
            g = draw_gap((n_accepted % 200) >= 140);
            if (g == 0 && pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                drive_cmd(cur_cmd);
            end else begin
                i_in_valid <= 1'b0;
                in_gap <= g;
            end
        end else if (!i_in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                drive_cmd(cur_cmd);
                i_in_valid <= 1'b1;
            end
        end
    end

    // Result monitor: checks each read against the oldest expectation and stalls at random.
    always @(posedge i_clk) begin : monitor_p
        int g;
        int want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            out_gap <= 0;
        end else if (o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_reads.size() == 0) begin
                if (n_errors < MAX_REPORTS)
                    $display("MISMATCH: read value %0d with no read pending", o_read_value);
                n_errors++;
            end else begin
                want = expected_reads.pop_front();
                if (o_read_value !== want) begin
                    if (n_errors < MAX_REPORTS)
                        $display("MISMATCH: read %0d expected %0d got %0d",
                                 n_results, want, o_read_value);
                    n_errors++;
                end
            end
            g = draw_gap((n_results % 100) >= 70);
            if (g > 0) begin
                i_out_ready <= 1'b0;
                out_gap <= g;
            end
        end else if (!i_out_ready && o_out_valid) begin
            // The stall counts down only while a result is actually waiting.
            if (out_gap <= 1) i_out_ready <= 1'b1;
            out_gap <= out_gap - 1;
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_rbm_gradient_accumulator: no transaction for %0d cycles", idle_cycles);
            $display("tb_rbm_gradient_accumulator: done, errors");
            $finish;
        end
    end

    // Stimulus generation, reset and end of run.
    initial begin : stimulus_p
        t_grad_cmd c;
        int v;
        int r;
        int useful;
        for (v = 0; v < 8; v++) mode_count[v] = 0;

        // Load every visible unit so that row updates only see written entries.
        for (v = 0; v < VISIBLE_COUNT; v++) begin
            c = random_cmd(MODE_LOAD);
            c.vis = VIS_W'(v);
            if ($urandom_range(0, 3) != 0) c.vval = VAL_W'($urandom_range(0, 32768));
            pending_cmds.push_back(c);
        end

        // Directed transactions: value extremes, edge rows and units, zero state,
        // ignored modes, and scaling by the largest factor and by zero.
        pending_cmds.push_back(make_cmd(MODE_LOAD, 1'b0, 6'd9, 8'd0, 16'h0000, 1'b1, 16'h1234));
        pending_cmds.push_back(make_cmd(MODE_LOAD, 1'b1, 6'd0, 8'd255, 16'hFFFF, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_LOAD, 1'b0, 6'd3, 8'd1, 16'h8000, 1'b0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(MODE_LOAD, 1'b1, 6'd63, 8'd2, 16'h8001, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_ROW, 1'b0, 6'd0, 8'd77, 16'h5555, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_ROW, 1'b1, 6'd63, 8'd255, 16'hFFFF, 1'b1, 16'hFFFF));
        pending_cmds.push_back(make_cmd(MODE_ROW, 1'b0, 6'd5, 8'd0, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_WGT, 1'b1, 6'd0, 8'd255, 16'hFFFF, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_WGT, 1'b0, 6'd63, 8'd1, 16'h0, 1'b0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(MODE_RD_WGT, 1'b0, 6'd5, 8'd2, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_HB, 1'b1, 6'd0, 8'd0, 16'h0, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_HB, 1'b0, 6'd63, 8'd255, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_VB, 1'b1, 6'd63, 8'd255, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_UNUSED_LO, 1'b0, 6'd1, 8'd1, 16'h7FFF, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_UNUSED_HI, 1'b1, 6'd2, 8'd2, 16'hFFFF, 1'b1, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_SCALE, 1'b1, 6'd0, 8'd0, 16'h0, 1'b0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(MODE_RD_WGT, 1'b0, 6'd63, 8'd255, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_HB, 1'b0, 6'd63, 8'd0, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_VB, 1'b0, 6'd0, 8'd2, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_SCALE, 1'b0, 6'd0, 8'd0, 16'h0, 1'b0, 16'h0000));
        pending_cmds.push_back(make_cmd(MODE_RD_WGT, 1'b0, 6'd0, 8'd0, 16'h0, 1'b0, 16'h0));
        pending_cmds.push_back(make_cmd(MODE_RD_VB, 1'b1, 6'd0, 8'd255, 16'h0, 1'b0, 16'h0));

        // Random mix, mostly loads, row updates and reads; scaling is rare since it is slow.
        useful = 0;
        while (useful < RANDOM_CMDS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                c = random_cmd(($urandom_range(0, 1) != 0) ? MODE_UNUSED_HI : MODE_UNUSED_LO);
            end else if (r < 4) begin
                c = random_cmd(MODE_SCALE);
                if ($urandom_range(0, 2) != 0) c.fac = FAC_W'($urandom_range(49152, 65535));
            end else if (r < 26) begin
                c = random_cmd(MODE_LOAD);
                if ($urandom_range(0, 7) != 0) c.vval = VAL_W'($urandom_range(0, 32768));
            end else if (r < 54) begin
                c = random_cmd(MODE_ROW);
                c.hval = ($urandom_range(0, 7) != 0);
            end else if (r < 80) begin
                c = random_cmd(MODE_RD_WGT);
            end else if (r < 90) begin
                c = random_cmd(MODE_RD_HB);
            end else begin
                c = random_cmd(MODE_RD_VB);
            end
            if (c.mode != MODE_UNUSED_LO && c.mode != MODE_UNUSED_HI &&
                !(c.mode == MODE_ROW && !c.hval))
                useful++;
            pending_cmds.push_back(c);
        end
        n_queued = pending_cmds.size();

        // Reset, then let the traffic run to completion.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < n_queued) @(posedge i_clk);
        while (expected_reads.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Accepted %0d transactions: %0d loads, %0d row updates, %0d scales, %0d ignored",
                 n_accepted, mode_count[MODE_LOAD], mode_count[MODE_ROW],
                 mode_count[MODE_SCALE], mode_count[MODE_UNUSED_LO] + mode_count[MODE_UNUSED_HI]);
        $display("Checked %0d reads (%0d weight, %0d hidden bias, %0d visible bias), %0d mismatches",
                 n_results, mode_count[MODE_RD_WGT], mode_count[MODE_RD_HB],
                 mode_count[MODE_RD_VB], n_errors);
        if (n_errors == 0 && expected_reads.size() == 0) begin
            $display("tb_rbm_gradient_accumulator: done, clean");
        end else begin
            $display("tb_rbm_gradient_accumulator: done, errors");
        end
        $finish;
    end

endmodule

// ----- rbm_gradient_accumulator.f -----
hdl/rbmga_pkg.sv
hdl/rbmga_ram.sv
hdl/rbmga_alu.sv
hdl/rbm_gradient_accumulator.sv
tb/tb_rbm_gradient_accumulator.sv
